[rtl/core/mig_pkg.sv]
// Shared constants, types and helper functions for the Monod growth-rate block.
package mig_pkg;

    // Fixed-point formats: unsigned Q8.40 inputs, signed Q7.40 outputs.
    localparam int unsigned DATA_W = 48;
    localparam int unsigned FRAC_W = 40;

    // Configuration port geometry.
    localparam int unsigned APB_DATA_W = 64;
    localparam int unsigned APB_ADDR_W = 6;
    localparam int unsigned REG_SEL_LSB = 3;

    // Ammonium released per thiocyanate consumed, 0.293 in Q0.40.
    localparam int unsigned NH4_W = 39;
    localparam logic [NH4_W-1:0] NH4_PER_SCN = 39'd322156906938;

    // Saturation limits of a signed 48-bit output.
    localparam logic [DATA_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_MIN = 48'h8000_0000_0000;

    // Register reset values.
    localparam logic [DATA_W-1:0] RST_MAX_GROWTH    = 48'd0;
    localparam logic [DATA_W-1:0] RST_SCN_HALF_SAT  = 48'd5497558139;
    localparam logic [DATA_W-1:0] RST_O2_HALF_SAT   = 48'd219902326;
    localparam logic [DATA_W-1:0] RST_HG_INHIB      = 48'd10995116278;
    localparam logic [DATA_W-1:0] RST_BIOMASS_YIELD = 48'd1099511627776;
    localparam logic [DATA_W-1:0] RST_MAINT_RATE    = 48'd0;
    localparam logic [DATA_W-1:0] RST_DECAY_RATE    = 48'd0;
    localparam logic [DATA_W-1:0] RST_HG_UPTAKE     = 48'd0;

    typedef logic [DATA_W-1:0] q40_t;

    // Register map, one register every eight bytes.
    typedef enum logic [2:0] {
        REG_MAX_GROWTH    = 3'd0,
        REG_SCN_HALF_SAT  = 3'd1,
        REG_O2_HALF_SAT   = 3'd2,
        REG_HG_INHIB      = 3'd3,
        REG_BIOMASS_YIELD = 3'd4,
        REG_MAINT_RATE    = 3'd5,
        REG_DECAY_RATE    = 3'd6,
        REG_HG_UPTAKE     = 3'd7
    } mig_reg_t;

    // Negate a magnitude, clamping it to the most negative 48-bit value.
    function automatic logic [DATA_W-1:0] neg_sat(input logic [63:0] mag);
        logic [63:0] lim;
        lim = (mag > 64'(NEG_MIN)) ? 64'(NEG_MIN) : mag;
        return DATA_W'(64'd0 - lim);
    endfunction

endpackage

[rtl/core/mig_if.sv]
// Item channel interfaces: grid cell items in, rate result items out.
interface mig_cell_if import mig_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] scn_conc;
    logic [DATA_W-1:0] o2_conc;
    logic [DATA_W-1:0] hg_conc;
    logic [DATA_W-1:0] biomass_density;
    logic              in_domain;

    modport source (output valid, scn_conc, o2_conc, hg_conc, biomass_density, in_domain,
                    input ready);
    modport sink (input valid, scn_conc, o2_conc, hg_conc, biomass_density, in_domain,
                  output ready);
endinterface

interface mig_rate_if import mig_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] scn_rate_delta;
    logic signed [DATA_W-1:0] nh4_rate_delta;
    logic signed [DATA_W-1:0] hg_rate_delta;
    logic signed [DATA_W-1:0] net_growth_rate;

    modport source (output valid, scn_rate_delta, nh4_rate_delta, hg_rate_delta,
                    net_growth_rate, input ready);
    modport sink (input valid, scn_rate_delta, nh4_rate_delta, hg_rate_delta,
                  net_growth_rate, output ready);
endinterface

[rtl/core/monod_inhibited_growth_rates.sv]
// Top level of the Monod growth-rate block with mercury inhibition.
//
// One grid cell item enters per clock while the pipeline advances, and rate items leave in
// order. The pipeline is built around two restoring divider pipelines that resolve one
// quotient bit per stage: the three Monod factors in 42 stages, then mu*X over the biomass
// yield in 52 stages. Around them sit six two-stage multipliers in series (eight in all) and
// an output register. The whole pipeline advances together. While a finished item waits at
// the output, the block keeps taking cells until the next item reaches the last multiplier
// stage. Configuration is through an APB-style port with 64-bit data, one 48-bit register
// every eight bytes; no clearing pass or warm-up is needed after reset.
module monod_inhibited_growth_rates import mig_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    mig_cell_if.sink              cell_item,
    mig_rate_if.source            rate_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned DIV_W  = DATA_W + 1;      // Monod denominator width
    localparam int unsigned FAC_W  = FRAC_W + 1;      // Monod factor, up to 1.0
    localparam int unsigned BR_W   = DATA_W + 8;      // mu*X and ku*Hg
    localparam int unsigned HGP_W  = 64;              // ku*Hg*X
    localparam int unsigned QD_W   = FRAC_W + 11;     // clamped quotient mu*X/Y
    localparam int unsigned OVF_SH = QD_W - FRAC_W;
    localparam int unsigned NHP_W  = QD_W + NH4_W - FRAC_W;
    localparam int unsigned NET_W  = DATA_W + 3;

    typedef struct packed {
        logic [FAC_W-1:0] fo;
        logic [FAC_W-1:0] fi;
        q40_t             hg;
        q40_t             dens;
        logic             in_dom;
    } fac_side_t;

    typedef struct packed {
        logic [FAC_W-1:0] fo;
        q40_t             hg;
        q40_t             dens;
        logic             in_dom;
    } mu_side_t;

    typedef struct packed {
        logic [BR_W-1:0] br;
        q40_t            mu;
        q40_t            maint;
        logic            in_dom;
    } hgp_side_t;

    typedef struct packed {
        logic  ovf;
        q40_t  net;
        q40_t  hgd;
        logic  in_dom;
    } q_side_t;

    typedef struct packed {
        logic [QD_W-1:0] q;
        q40_t            net;
        q40_t            hgd;
        logic            in_dom;
    } nh4_side_t;

    // Configuration registers.
    q40_t max_growth_reg;
    q40_t scn_half_sat_reg;
    q40_t o2_half_sat_reg;
    q40_t hg_inhib_reg;
    q40_t biomass_yield_reg;
    q40_t maint_rate_reg;
    q40_t decay_rate_reg;
    q40_t hg_uptake_reg;

    mig_reg_t reg_sel;
    logic     cfg_write;

    assign reg_sel   = mig_reg_t'(paddr[APB_ADDR_W-1:REG_SEL_LSB]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_growth_reg    <= RST_MAX_GROWTH;
            scn_half_sat_reg  <= RST_SCN_HALF_SAT;
            o2_half_sat_reg   <= RST_O2_HALF_SAT;
            hg_inhib_reg      <= RST_HG_INHIB;
            biomass_yield_reg <= RST_BIOMASS_YIELD;
            maint_rate_reg    <= RST_MAINT_RATE;
            decay_rate_reg    <= RST_DECAY_RATE;
            hg_uptake_reg     <= RST_HG_UPTAKE;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_MAX_GROWTH:    max_growth_reg    <= pwdata[DATA_W-1:0];
                REG_SCN_HALF_SAT:  scn_half_sat_reg  <= pwdata[DATA_W-1:0];
                REG_O2_HALF_SAT:   o2_half_sat_reg   <= pwdata[DATA_W-1:0];
                REG_HG_INHIB:      hg_inhib_reg      <= pwdata[DATA_W-1:0];
                REG_BIOMASS_YIELD: biomass_yield_reg <= pwdata[DATA_W-1:0];
                REG_MAINT_RATE:    maint_rate_reg    <= pwdata[DATA_W-1:0];
                REG_DECAY_RATE:    decay_rate_reg    <= pwdata[DATA_W-1:0];
                REG_HG_UPTAKE:     hg_uptake_reg     <= pwdata[DATA_W-1:0];
                default:           ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_sel)
            REG_MAX_GROWTH:    prdata = APB_DATA_W'(max_growth_reg);
            REG_SCN_HALF_SAT:  prdata = APB_DATA_W'(scn_half_sat_reg);
            REG_O2_HALF_SAT:   prdata = APB_DATA_W'(o2_half_sat_reg);
            REG_HG_INHIB:      prdata = APB_DATA_W'(hg_inhib_reg);
            REG_BIOMASS_YIELD: prdata = APB_DATA_W'(biomass_yield_reg);
            REG_MAINT_RATE:    prdata = APB_DATA_W'(maint_rate_reg);
            REG_DECAY_RATE:    prdata = APB_DATA_W'(decay_rate_reg);
            REG_HG_UPTAKE:     prdata = APB_DATA_W'(hg_uptake_reg);
            default:           prdata = '0;
        endcase
    end

    // Pipeline advance: the output register is free, or the last stage holds no item.
    logic out_v_reg;
    logic out_free;
    logic en;
    logic m6_v;

    assign out_free        = !out_v_reg || rate_item.ready;
    assign en              = out_free || !m6_v;
    assign cell_item.ready = en;

    // Monod factors: S/(Ks+S), O/(Ko+O) and Ki/(Ki+Hg).
    logic [DIV_W-1:0] den_s, den_o, den_i;
    logic [FAC_W-1:0] fs, fo, fi;
    q40_t             ds_hg, do_dens;
    logic             di_inside;
    logic             vs, vo, vi;

    assign den_s = {1'b0, scn_half_sat_reg} + {1'b0, cell_item.scn_conc};
    assign den_o = {1'b0, o2_half_sat_reg}  + {1'b0, cell_item.o2_conc};
    assign den_i = {1'b0, hg_inhib_reg}     + {1'b0, cell_item.hg_conc};

    mig_div #(.DW(DIV_W), .QB(FAC_W), .SW(DATA_W)) u_div_scn (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(cell_item.valid),
        .zero_in(cell_item.scn_conc == '0),
        .r_init({2'b00, cell_item.scn_conc[DATA_W-1:1]}),
        .d(den_s),
        .feed({cell_item.scn_conc[0], FRAC_W'(0)}),
        .side_in(cell_item.hg_conc),
        .v_out(vs), .q(fs), .side_out(ds_hg)
    );

    mig_div #(.DW(DIV_W), .QB(FAC_W), .SW(DATA_W)) u_div_o2 (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(cell_item.valid),
        .zero_in(cell_item.o2_conc == '0),
        .r_init({2'b00, cell_item.o2_conc[DATA_W-1:1]}),
        .d(den_o),
        .feed({cell_item.o2_conc[0], FRAC_W'(0)}),
        .side_in(cell_item.biomass_density),
        .v_out(vo), .q(fo), .side_out(do_dens)
    );

    mig_div #(.DW(DIV_W), .QB(FAC_W), .SW(1)) u_div_hg (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(cell_item.valid),
        .zero_in(hg_inhib_reg == '0),
        .r_init({2'b00, hg_inhib_reg[DATA_W-1:1]}),
        .d(den_i),
        .feed({hg_inhib_reg[0], FRAC_W'(0)}),
        .side_in(cell_item.in_domain),
        .v_out(vi), .q(fi), .side_out(di_inside)
    );

    // mu = max_growth * fs * fo * fi, one product per multiplier.
    fac_side_t m1_side_in, m1_side, m2_side_in, m2_side;
    mu_side_t  m3_side_in, m3_side;
    q40_t      mu1, mu2, mu;
    logic      m1_v, m2_v, m3_v;

    assign m1_side_in = '{fo: fo, fi: fi, hg: ds_hg, dens: do_dens, in_dom: di_inside};

    mig_mul #(.AW(DATA_W), .BW(FAC_W), .RW(DATA_W), .SW($bits(fac_side_t))) u_mul_fs (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(vs && vo && vi),
        .a(max_growth_reg), .b(fs), .side_in(m1_side_in),
        .v_out(m1_v), .p(mu1), .side_out(m1_side)
    );

    assign m2_side_in = m1_side;

    mig_mul #(.AW(DATA_W), .BW(FAC_W), .RW(DATA_W), .SW($bits(fac_side_t))) u_mul_fo (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(m1_v),
        .a(mu1), .b(m1_side.fo), .side_in(m2_side_in),
        .v_out(m2_v), .p(mu2), .side_out(m2_side)
    );

    assign m3_side_in = '{fo: m2_side.fo, hg: m2_side.hg, dens: m2_side.dens,
                          in_dom: m2_side.in_dom};

    mig_mul #(.AW(DATA_W), .BW(FAC_W), .RW(DATA_W), .SW($bits(mu_side_t))) u_mul_fi (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(m2_v),
        .a(mu2), .b(m2_side.fi), .side_in(m3_side_in),
        .v_out(m3_v), .p(mu), .side_out(m3_side)
    );

    // Biomass turnover mu*X, maintenance and the first mercury product side by side.
    logic [BR_W-1:0] br, hgp1;
    q40_t            maint, br_mu, h1_dens;
    logic            mt_inside;
    logic            vbr, vmt, vh1;

    mig_mul #(.AW(DATA_W), .BW(DATA_W), .RW(BR_W), .SW(DATA_W)) u_mul_br (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(m3_v),
        .a(mu), .b(m3_side.dens), .side_in(mu),
        .v_out(vbr), .p(br), .side_out(br_mu)
    );

    mig_mul #(.AW(DATA_W), .BW(FAC_W), .RW(DATA_W), .SW(1)) u_mul_maint (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(m3_v),
        .a(maint_rate_reg), .b(m3_side.fo), .side_in(m3_side.in_dom),
        .v_out(vmt), .p(maint), .side_out(mt_inside)
    );

    mig_mul #(.AW(DATA_W), .BW(DATA_W), .RW(BR_W), .SW(DATA_W)) u_mul_hg1 (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(m3_v),
        .a(hg_uptake_reg), .b(m3_side.hg), .side_in(m3_side.dens),
        .v_out(vh1), .p(hgp1), .side_out(h1_dens)
    );

    // Mercury uptake ku*Hg*X.
    hgp_side_t        m5_side_in, m5_side;
    logic [HGP_W-1:0] hgp;
    logic             m5_v;

    assign m5_side_in = '{br: br, mu: br_mu, maint: maint, in_dom: mt_inside};

    mig_mul #(.AW(BR_W), .BW(DATA_W), .RW(HGP_W), .SW($bits(hgp_side_t))) u_mul_hg2 (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(vbr && vmt && vh1),
        .a(hgp1), .b(h1_dens), .side_in(m5_side_in),
        .v_out(m5_v), .p(hgp), .side_out(m5_side)
    );

    // Net growth rate and the overflow test of the yield quotient.
    logic signed [NET_W-1:0] net_full;
    q40_t                    net_sat;
    logic                    q_ovf;
    q_side_t                 d4_side_in, d4_side;
    logic [QD_W-1:0]         q_div, q_eff;
    logic                    d4_v;

    always_comb
    begin
        net_full = $signed({3'b000, m5_side.mu}) - $signed({3'b000, m5_side.maint})
                 - $signed({3'b000, decay_rate_reg});
        if (net_full > $signed({3'b000, POS_MAX}))
        begin
            net_sat = POS_MAX;
        end
        else if (net_full < $signed({3'b111, NEG_MIN}))
        begin
            net_sat = NEG_MIN;
        end
        else
        begin
            net_sat = net_full[DATA_W-1:0];
        end
    end

    // The quotient would not fit its width: both scn and nh4 saturate anyway.
    // A zero numerator never overflows, not even over a zero yield.
    assign q_ovf = (m5_side.br != '0)
                && ({3'b000, m5_side.br} >= {biomass_yield_reg, OVF_SH'(0)});

    assign d4_side_in = '{ovf: q_ovf, net: net_sat, hgd: neg_sat(hgp),
                          in_dom: m5_side.in_dom};

    mig_div #(.DW(DATA_W), .QB(QD_W), .SW($bits(q_side_t))) u_div_yield (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(m5_v),
        .zero_in(m5_side.br == '0),
        .r_init(DATA_W'(m5_side.br[BR_W-1:OVF_SH])),
        .d(biomass_yield_reg),
        .feed({m5_side.br[OVF_SH-1:0], FRAC_W'(0)}),
        .side_in(d4_side_in),
        .v_out(d4_v), .q(q_div), .side_out(d4_side)
    );

    assign q_eff = d4_side.ovf ? '1 : q_div;

    // Ammonium release 0.293*q.
    nh4_side_t        m6_side_in, m6_side;
    logic [NHP_W-1:0] nh4p;

    assign m6_side_in = '{q: q_eff, net: d4_side.net, hgd: d4_side.hgd,
                          in_dom: d4_side.in_dom};

    mig_mul #(.AW(QD_W), .BW(NH4_W), .RW(NHP_W), .SW($bits(nh4_side_t))) u_mul_nh4 (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(d4_v),
        .a(q_eff), .b(NH4_PER_SCN), .side_in(m6_side_in),
        .v_out(m6_v), .p(nh4p), .side_out(m6_side)
    );

    // Output register; cells outside the domain give zero deltas.
    q40_t scn_reg, nh4_reg, hg_reg, net_reg;
    q40_t scn_next, nh4_next, hg_next;

    always_comb
    begin
        if (m6_side.in_dom)
        begin
            scn_next = neg_sat(64'(m6_side.q));
            nh4_next = (nh4p > NHP_W'(POS_MAX)) ? POS_MAX : nh4p[DATA_W-1:0];
            hg_next  = m6_side.hgd;
        end
        else
        begin
            scn_next = '0;
            nh4_next = '0;
            hg_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_v_reg <= m6_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            scn_reg <= scn_next;
            nh4_reg <= nh4_next;
            hg_reg  <= hg_next;
            net_reg <= m6_side.net;
        end
    end

    assign rate_item.valid           = out_v_reg;
    assign rate_item.scn_rate_delta  = scn_reg;
    assign rate_item.nh4_rate_delta  = nh4_reg;
    assign rate_item.hg_rate_delta   = hg_reg;
    assign rate_item.net_growth_rate = net_reg;

endmodule

[rtl/core/mig_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
module mig_div #(
    parameter int unsigned DW = 49,
    parameter int unsigned QB = 41,
    parameter int unsigned SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          v_in,
    input  logic          zero_in,
    input  logic [DW-1:0] r_init,
    input  logic [DW-1:0] d,
    input  logic [QB-1:0] feed,
    input  logic [SW-1:0] side_in,
    output logic          v_out,
    output logic [QB-1:0] q,
    output logic [SW-1:0] side_out
);

    logic [QB:0]   v_reg;
    logic [QB:0]   z_reg;
    logic [DW-1:0] r_reg [QB];
    logic [DW-1:0] d_reg [QB];
    logic [QB-1:0] f_reg [QB];
    logic [QB-1:0] q_reg [QB+1];
    logic [SW-1:0] s_reg [QB+1];

    logic [DW-1:0] r_next [QB];
    logic [QB-1:0] f_next [QB];
    logic [QB-1:0] q_next [QB];

    // Each stage shifts in one numerator bit and tries one subtraction.
    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [DW:0] trial;
        logic        ge;
        assign trial     = {r_reg[k], f_reg[k][QB-1]};
        assign ge        = (trial >= {1'b0, d_reg[k]});
        assign r_next[k] = ge ? (trial[DW-1:0] - d_reg[k]) : trial[DW-1:0];
        assign f_next[k] = {f_reg[k][QB-2:0], 1'b0};
        assign q_next[k] = {q_reg[k][QB-2:0], ge};
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[QB-1:0], v_in};
        end
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= r_init;
            d_reg[0] <= d;
            f_reg[0] <= feed;
            q_reg[0] <= '0;
            s_reg[0] <= side_in;
            z_reg    <= {z_reg[QB-1:0], zero_in};
            for (int i = 0; i < QB - 1; i++)
            begin
                r_reg[i+1] <= r_next[i];
                d_reg[i+1] <= d_reg[i];
                f_reg[i+1] <= f_next[i];
            end
            for (int i = 0; i < QB; i++)
            begin
                q_reg[i+1] <= q_next[i];
                s_reg[i+1] <= s_reg[i];
            end
        end
    end

    // A zero numerator always gives a zero quotient, even over a zero divisor.
    assign v_out    = v_reg[QB];
    assign q        = z_reg[QB] ? '0 : q_reg[QB];
    assign side_out = s_reg[QB];

endmodule

[rtl/core/mig_mul.sv]
// Two-stage fixed-point multiplier: partial products, then sum and Q40 rescale.
module mig_mul import mig_pkg::*; #(
    parameter int unsigned AW = 48,
    parameter int unsigned BW = 41,
    parameter int unsigned RW = 48,
    parameter int unsigned SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          v_in,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    input  logic [SW-1:0] side_in,
    output logic          v_out,
    output logic [RW-1:0] p,
    output logic [SW-1:0] side_out
);

    localparam int unsigned HA = (AW + 1) / 2;
    localparam int unsigned LA = AW - HA;
    localparam int unsigned HB = (BW + 1) / 2;
    localparam int unsigned LB = BW - HB;
    localparam int unsigned PW = AW + BW;

    logic [1:0]          v_reg;
    logic [HA+HB-1:0]    ll_reg;
    logic [HA+LB-1:0]    lh_reg;
    logic [LA+HB-1:0]    hl_reg;
    logic [LA+LB-1:0]    hh_reg;
    logic [SW-1:0]       s1_reg;
    logic [RW-1:0]       p_reg;
    logic [SW-1:0]       s2_reg;

    logic [HA+HB-1:0]    ll_next;
    logic [HA+LB-1:0]    lh_next;
    logic [LA+HB-1:0]    hl_next;
    logic [LA+LB-1:0]    hh_next;
    logic [PW-1:0]       sum;

    // Four half-width products.
    always_comb
    begin
        ll_next = (HA+HB)'(a[HA-1:0])  * (HA+HB)'(b[HB-1:0]);
        lh_next = (HA+LB)'(a[HA-1:0])  * (HA+LB)'(b[BW-1:HB]);
        hl_next = (LA+HB)'(a[AW-1:HA]) * (LA+HB)'(b[HB-1:0]);
        hh_next = (LA+LB)'(a[AW-1:HA]) * (LA+LB)'(b[BW-1:HB]);
    end

    // Recombine and drop the fraction bits of one operand.
    always_comb
    begin
        sum = PW'(ll_reg) + (PW'(lh_reg) << HB) + (PW'(hl_reg) << HA)
            + (PW'(hh_reg) << (HA + HB));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[0], v_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
            s1_reg <= side_in;
            p_reg  <= sum[FRAC_W +: RW];
            s2_reg <= s1_reg;
        end
    end

    assign v_out    = v_reg[1];
    assign p        = p_reg;
    assign side_out = s2_reg;

endmodule

[rtl/core/mig_checker.sv]
// Port-level assertions for the growth-rate block, bound to its top level.
module mig_checker import mig_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] scn,
    input logic signed [DATA_W-1:0] nh4,
    input logic signed [DATA_W-1:0] hg,
    input logic signed [DATA_W-1:0] net
);

    // A stalled result item stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scn) && $stable(nh4)
                                    && $stable(hg) && $stable(net))
        else $error("result item changed while stalled");

    // Consumption deltas are never positive.
    a_consume_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (scn == '0 || scn[DATA_W-1]) && (hg == '0 || hg[DATA_W-1]))
        else $error("thiocyanate or mercury delta is positive");

    // Ammonium is released only where thiocyanate is consumed.
    a_nh4_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !nh4[DATA_W-1] && (nh4 == '0 || scn != '0))
        else $error("ammonium delta without thiocyanate consumption");

    // The input side stalls only behind a blocked output.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output is free");

endmodule

bind monod_inhibited_growth_rates mig_checker u_mig_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(cell_item.valid),
    .in_ready(cell_item.ready),
    .out_valid(rate_item.valid),
    .out_ready(rate_item.ready),
    .scn(rate_item.scn_rate_delta),
    .nh4(rate_item.nh4_rate_delta),
    .hg(rate_item.hg_rate_delta),
    .net(rate_item.net_growth_rate)
);

[dv/monod_inhibited_growth_rates_tb.sv]
// Self-checking testbench for the Monod growth-rate block: random and directed cells.
module monod_inhibited_growth_rates_tb import mig_pkg::*; ();

    localparam int unsigned PIPE_DRAIN = 120;
    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned NUM_PHASES = 7;

    typedef struct packed {
        logic [DATA_W-1:0] scn;
        logic [DATA_W-1:0] o2;
        logic [DATA_W-1:0] hg;
        logic [DATA_W-1:0] dens;
        logic              in_dom;
    } cell_t;

    typedef struct packed {
        logic [DATA_W-1:0] scn_delta;
        logic [DATA_W-1:0] nh4_delta;
        logic [DATA_W-1:0] hg_delta;
        logic [DATA_W-1:0] net_rate;
    } rates_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    mig_cell_if cell_ch ();
    mig_rate_if rate_ch ();

    monod_inhibited_growth_rates u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_item (cell_ch.sink),
        .rate_item (rate_ch.source),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Local copy of the rate registers, indexed by register code.
    logic [DATA_W-1:0] rate_regs [8];

    cell_t  cells_pending [$];
    rates_t rates_expected [$];
    int     error_count = 0;
    bit     idling_on = 1'b1;
    bit     cell_taken = 1'b0;
    int     src_gap = 0;
    int     sink_gap = 0;
    int     quiet_cycles = 0;

    always #1 clk = ~clk;

    // Truncating Q40 product, saturated to all ones when it overflows 64 bits.
    function automatic logic [63:0] q40_product(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:104] != 0)
            return '1;
        return p[103:40];
    endfunction

    // Truncating Q40 quotient clamped to cap; a zero dividend gives zero, else a zero divisor gives cap.
    function automatic logic [63:0] q40_quotient(logic [63:0] a, logic [63:0] b,
                                                 logic [63:0] cap);
        logic [127:0] q;
        if (a == 0)
            return 64'd0;
        if (b == 0)
            return cap;
        q = {24'd0, a, 40'd0} / {64'd0, b};
        return (q > {64'd0, cap}) ? cap : q[63:0];
    endfunction

    function automatic logic [DATA_W-1:0] negate_clamped(logic [63:0] mag);
        logic [63:0] m;
        m = (mag > 64'h8000_0000_0000) ? 64'h8000_0000_0000 : mag;
        return DATA_W'(64'd0 - m);
    endfunction

    // Growth rate and rate deltas of one cell under the current registers.
    function automatic rates_t predict_rates(cell_t c);
        rates_t r;
        logic [63:0] cap;
        logic [63:0] f_scn;
        logic [63:0] f_o2;
        logic [63:0] f_hg;
        logic [63:0] mu;
        logic [63:0] maint;
        logic [63:0] bio;
        logic [63:0] q;
        logic [63:0] nh4;
        logic signed [65:0] net;
        cap = 64'd1 << 63;
        f_scn = q40_quotient(64'(c.scn), 64'(rate_regs[REG_SCN_HALF_SAT]) + 64'(c.scn), cap);
        f_o2 = q40_quotient(64'(c.o2), 64'(rate_regs[REG_O2_HALF_SAT]) + 64'(c.o2), cap);
        f_hg = q40_quotient(64'(rate_regs[REG_HG_INHIB]),
                            64'(rate_regs[REG_HG_INHIB]) + 64'(c.hg), cap);
        mu = q40_product(q40_product(q40_product(64'(rate_regs[REG_MAX_GROWTH]), f_scn),
                                     f_o2), f_hg);
        maint = q40_product(64'(rate_regs[REG_MAINT_RATE]), f_o2);
        net = $signed({2'b00, mu}) - $signed({2'b00, maint})
              - $signed({18'd0, rate_regs[REG_DECAY_RATE]});
        if (net > $signed(66'h7FFF_FFFF_FFFF))
            net = 66'h7FFF_FFFF_FFFF;
        if (net < -$signed(66'h8000_0000_0000))
            net = -$signed(66'h8000_0000_0000);
        r.net_rate = net[DATA_W-1:0];
        r.scn_delta = '0;
        r.nh4_delta = '0;
        r.hg_delta = '0;
        if (c.in_dom)
        begin
            bio = q40_product(mu, 64'(c.dens));
            q = q40_quotient(bio, 64'(rate_regs[REG_BIOMASS_YIELD]), cap);
            r.scn_delta = negate_clamped(q);
            nh4 = q40_product(q, 64'(NH4_PER_SCN));
            r.nh4_delta = (nh4 > 64'(POS_MAX)) ? POS_MAX : nh4[DATA_W-1:0];
            if (rate_regs[REG_HG_UPTAKE] != 0 && c.hg != 0)
                r.hg_delta = negate_clamped(
                    q40_product(q40_product(64'(rate_regs[REG_HG_UPTAKE]), 64'(c.hg)),
                                64'(c.dens)));
        end
        return r;
    endfunction

    // Random values biased toward the floor value, the top and small magnitudes.
    function automatic logic [DATA_W-1:0] pick_value(logic [DATA_W-1:0] floor_val);
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = floor_val;
            1: v = '1;
            2: v = DATA_W'($urandom_range(0, 255));
            3, 4: v = DATA_W'({$urandom, $urandom} >> $urandom_range(0, 40));
            default: v = DATA_W'({$urandom, $urandom});
        endcase
        return (v < floor_val) ? floor_val : v;
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        c.scn = pick_value('0);
        c.o2 = pick_value('0);
        c.hg = pick_value('0);
        c.dens = pick_value('0);
        c.in_dom = ($urandom_range(0, 3) != 0);
        return c;
    endfunction

    task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $time);
        error_count++;
    endtask

    // Register write with a setup phase and an access phase; the local copy follows at the access edge.
    task automatic write_reg(mig_reg_t idx, logic [DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(idx) << REG_SEL_LSB;
        pwdata <= APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rate_regs[idx] = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (cells_pending.size() != 0 || cell_ch.valid || rates_expected.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    function automatic cell_t make_cell(logic [DATA_W-1:0] s, logic [DATA_W-1:0] o,
                                        logic [DATA_W-1:0] h, logic [DATA_W-1:0] d,
                                        logic in_dom);
        cell_t c;
        c.scn = s;
        c.o2 = o;
        c.hg = h;
        c.dens = d;
        c.in_dom = in_dom;
        return c;
    endfunction

    // Cell driver: presents queued items at the falling edge, with random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
            cell_ch.valid <= 1'b0;
        else if (!cell_ch.valid || cell_taken)
        begin
            cell_taken = 1'b0;
            if (src_gap > 0)
            begin
                src_gap--;
                cell_ch.valid <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 9) == 0)
            begin
                src_gap = $urandom_range(0, 16);
                cell_ch.valid <= 1'b0;
            end
            else if (cells_pending.size() != 0)
            begin
                cell_t c;
                c = cells_pending.pop_front();
                cell_ch.scn_conc <= c.scn;
                cell_ch.o2_conc <= c.o2;
                cell_ch.hg_conc <= c.hg;
                cell_ch.biomass_density <= c.dens;
                cell_ch.in_domain <= c.in_dom;
                cell_ch.valid <= 1'b1;
            end
            else
                cell_ch.valid <= 1'b0;
        end
    end

    // Result sink: ready drops in random bursts.
    always @(negedge clk)
    begin
        if (sink_gap > 0)
        begin
            sink_gap--;
            rate_ch.ready <= 1'b0;
        end
        else if (idling_on && rst_n && $urandom_range(0, 9) == 0)
        begin
            sink_gap = $urandom_range(0, 16);
            rate_ch.ready <= 1'b0;
        end
        else
            rate_ch.ready <= 1'b1;
    end

    // Monitor: predicts on cell acceptance, checks on result acceptance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cell_ch.valid && cell_ch.ready)
            begin
                cell_taken = 1'b1;
                rates_expected.push_back(predict_rates(make_cell(cell_ch.scn_conc,
                    cell_ch.o2_conc, cell_ch.hg_conc, cell_ch.biomass_density,
                    cell_ch.in_domain)));
            end
            if (rate_ch.valid && rate_ch.ready)
            begin
                if (rates_expected.size() == 0)
                begin
                    report_mismatch("unexpected result item", rate_ch.scn_rate_delta, '0);
                end
                else
                begin
                    rates_t want;
                    want = rates_expected.pop_front();
                    if (rate_ch.scn_rate_delta !== want.scn_delta)
                        report_mismatch("scn_rate_delta", rate_ch.scn_rate_delta, want.scn_delta);
                    if (rate_ch.nh4_rate_delta !== want.nh4_delta)
                        report_mismatch("nh4_rate_delta", rate_ch.nh4_rate_delta, want.nh4_delta);
                    if (rate_ch.hg_rate_delta !== want.hg_delta)
                        report_mismatch("hg_rate_delta", rate_ch.hg_rate_delta, want.hg_delta);
                    if (rate_ch.net_growth_rate !== want.net_rate)
                        report_mismatch("net_growth_rate", rate_ch.net_growth_rate,
                                        want.net_rate);
                end
            end
        end
    end

    // Watchdog on cycles in which nothing moves on any port.
    always @(posedge clk)
    begin
        if ((cell_ch.valid && cell_ch.ready) || (rate_ch.valid && rate_ch.ready)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cell_ch.valid = 1'b0;
        cell_ch.scn_conc = '0;
        cell_ch.o2_conc = '0;
        cell_ch.hg_conc = '0;
        cell_ch.biomass_density = '0;
        cell_ch.in_domain = 1'b0;
        rate_ch.ready = 1'b0;
        rate_regs[REG_MAX_GROWTH] = RST_MAX_GROWTH;
        rate_regs[REG_SCN_HALF_SAT] = RST_SCN_HALF_SAT;
        rate_regs[REG_O2_HALF_SAT] = RST_O2_HALF_SAT;
        rate_regs[REG_HG_INHIB] = RST_HG_INHIB;
        rate_regs[REG_BIOMASS_YIELD] = RST_BIOMASS_YIELD;
        rate_regs[REG_MAINT_RATE] = RST_MAINT_RATE;
        rate_regs[REG_DECAY_RATE] = RST_DECAY_RATE;
        rate_regs[REG_HG_UPTAKE] = RST_HG_UPTAKE;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A few cells under the reset settings.
        for (int i = 0; i < 8; i++)
            cells_pending.push_back(random_cell());
        wait_idle();

        // Directed cells with moderate rates and uptake enabled.
        write_reg(REG_MAX_GROWTH, 48'd1099511627776);
        write_reg(REG_MAINT_RATE, 48'd10995116277);
        write_reg(REG_DECAY_RATE, 48'd1099511627);
        write_reg(REG_HG_UPTAKE, 48'd109951162777);
        cells_pending.push_back(make_cell('0, '0, '0, '0, 1'b1));
        cells_pending.push_back(make_cell('1, '1, '1, '1, 1'b1));
        cells_pending.push_back(make_cell('1, '1, '0, '1, 1'b1));
        cells_pending.push_back(make_cell('1, '1, '1, '1, 1'b0));
        cells_pending.push_back(make_cell('0, '1, 48'd5, '1, 1'b1));
        cells_pending.push_back(make_cell('1, '0, 48'd5, '1, 1'b1));
        cells_pending.push_back(make_cell(48'h10_0000_0000, 48'h10_0000_0000, '0,
                                          48'h100_0000_0000, 1'b1));
        cells_pending.push_back(make_cell(48'h10_0000_0000, 48'h10_0000_0000, 48'd1,
                                          48'h100_0000_0000, 1'b0));
        cells_pending.push_back(make_cell(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                                          48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b1));
        cells_pending.push_back(make_cell(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
                                          48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b1));
        cells_pending.push_back(make_cell(48'd1, 48'd1, 48'd1, 48'd1, 1'b1));
        wait_idle();

        // Extremes: every register at its top, then every register at its bottom.
        for (int r = 0; r < 8; r++)
            write_reg(mig_reg_t'(r), '1);
        for (int i = 0; i < 30; i++)
            cells_pending.push_back(random_cell());
        wait_idle();
        for (int r = 0; r < 8; r++)
            write_reg(mig_reg_t'(r), (r == REG_MAX_GROWTH || r >= REG_MAINT_RATE) ? '0 : 48'd1);
        for (int i = 0; i < 30; i++)
            cells_pending.push_back(random_cell());
        wait_idle();

        // Random settings; the last phase runs with no idling.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            for (int r = 0; r < 8; r++)
                write_reg(mig_reg_t'(r), pick_value((r == REG_MAX_GROWTH || r >= REG_MAINT_RATE)
                                                    ? 48'd0 : 48'd1));
            if (p == NUM_PHASES - 1)
                idling_on = 1'b0;
            for (int i = 0; i < 60; i++)
                cells_pending.push_back(random_cell());
            wait_idle();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
rtl/core/mig_pkg.sv
rtl/core/mig_if.sv
rtl/core/mig_div.sv
rtl/core/mig_mul.sv
rtl/core/monod_inhibited_growth_rates.sv
rtl/core/mig_checker.sv
dv/monod_inhibited_growth_rates_tb.sv
